### rtl/core/albar_pkg.sv
// ----------------------------------------------------------------------------
// albar_pkg: shared types and constants
// Fixed field widths, display codes and the back-end state type used by the
// averaged level bar graph.
// ----------------------------------------------------------------------------
package albar_pkg;

    localparam int PERIOD_W      = 16;
    localparam int CHAR_W        = 8;
    localparam int COLUMN_W      = 4;
    localparam int OUT_DATA_W    = 16;   // char_code + column, padded to bytes
    localparam int PIXEL_DIVISOR = 13;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd625;
    localparam logic [CHAR_W-1:0]   SPACE_CODE   = 8'd32;

    typedef enum logic
    {
        BK_IDLE,
        BK_DRAW
    } back_state_t;

endpackage

### rtl/core/albar_front.sv
// ----------------------------------------------------------------------------
// albar_front: sample intake
// Keeps the leaky running sum and the refresh countdown; on a redraw it
// pushes the pre-update average into the queue.
// ----------------------------------------------------------------------------
module albar_front #(
    parameter int SAMPLE_BITS   = 10,
    parameter int AVERAGE_SHIFT = 3,
    parameter int IN_W          = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_W-1:0]               s_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [albar_pkg::PERIOD_W-1:0] cfg_data,
    output logic                          q_push,
    output logic [SAMPLE_BITS-1:0]        q_data,
    input  logic                          q_full
);

    localparam int SUM_W = SAMPLE_BITS + AVERAGE_SHIFT;

    logic [SUM_W-1:0]                 sum_reg, sum_next;
    logic [albar_pkg::PERIOD_W-1:0]   cd_reg, cd_next, cd_dec;
    logic [albar_pkg::PERIOD_W-1:0]   period_reg;
    logic [SAMPLE_BITS-1:0]           avg;
    logic                             accept;
    logic                             redraw;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    assign avg = SAMPLE_BITS'(sum_reg >> AVERAGE_SHIFT);

    always_comb
    begin
        sum_next = sum_reg + SUM_W'(s_tdata[SAMPLE_BITS-1:0]) - SUM_W'(avg);
        cd_dec   = (cd_reg != '0) ? cd_reg - 1'b1 : cd_reg;
        redraw   = (cd_dec == '0);
        cd_next  = redraw ? period_reg : cd_dec;
    end

    assign q_push = accept && redraw;
    assign q_data = avg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            cd_reg     <= '0;
            period_reg <= albar_pkg::PERIOD_RESET;
        end
        else
        begin
            if (accept)
            begin
                sum_reg <= sum_next;
                cd_reg  <= cd_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                period_reg <= cfg_data;
            end
        end
    end

endmodule

### rtl/core/albar_queue.sv
// ----------------------------------------------------------------------------
// albar_queue: two-entry average queue
// Decouples sample intake from bar graph drawing.
// ----------------------------------------------------------------------------
module albar_queue #(
    parameter int DATA_W = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### rtl/core/albar_back.sv
// ----------------------------------------------------------------------------
// albar_back: bar graph drawing
// Turns one queued average into a pixel count and walks the columns,
// one character per cycle while the output slot is free, into the output register.
// ----------------------------------------------------------------------------
module albar_back #(
    parameter int SAMPLE_BITS       = 10,
    parameter int COLUMNS           = 16,
    parameter int PIXELS_PER_COLUMN = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  logic [SAMPLE_BITS-1:0]           q_data,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [albar_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                             m_tlast
);

    localparam int MAX_PIX   = COLUMNS * PIXELS_PER_COLUMN;
    localparam int PIX_W     = $clog2(MAX_PIX + 1);
    localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int DIV_SHIFT = SAMPLE_BITS + $clog2(albar_pkg::PIXEL_DIVISOR);
    // ceil(2^DIV_SHIFT / 13): exact floor division for any SAMPLE_BITS-bit value
    localparam int RECIP     = ((1 << DIV_SHIFT) + albar_pkg::PIXEL_DIVISOR - 1)
                               / albar_pkg::PIXEL_DIVISOR;
    localparam int PROD_W    = 2 * SAMPLE_BITS + 1;
    localparam int CMP_W     = (SAMPLE_BITS > PIX_W) ? SAMPLE_BITS : PIX_W;

    albar_pkg::back_state_t state_reg, state_next;

    logic [PROD_W-1:0]              prod;
    logic [CMP_W-1:0]               quot;
    logic [PIX_W-1:0]               pix_sat;
    logic [PIX_W-1:0]               pix_reg;
    logic [PIX_W-1:0]               used_reg;
    logic [PIX_W-1:0]               rem;
    logic [COL_W-1:0]               col_reg;
    logic                           col_last;
    logic                           slot_free;
    logic                           emit;
    logic [albar_pkg::CHAR_W-1:0]   glyph;

    logic                           out_valid_reg;
    logic [albar_pkg::CHAR_W-1:0]   out_char_reg;
    logic [albar_pkg::COLUMN_W-1:0] out_col_reg;
    logic                           out_last_reg;

    always_comb
    begin
        prod    = PROD_W'(q_data) * PROD_W'(RECIP);
        quot    = CMP_W'(prod >> DIV_SHIFT);
        pix_sat = (quot > CMP_W'(MAX_PIX)) ? PIX_W'(MAX_PIX) : PIX_W'(quot);
    end

    always_comb
    begin
        rem = pix_reg - used_reg;
        if (pix_reg <= used_reg)
        begin
            glyph = albar_pkg::SPACE_CODE;
        end
        else if (rem >= PIX_W'(PIXELS_PER_COLUMN))
        begin
            glyph = albar_pkg::CHAR_W'(PIXELS_PER_COLUMN - 1);
        end
        else
        begin
            glyph = albar_pkg::CHAR_W'(rem - 1'b1);
        end
    end

    assign col_last  = (col_reg == COL_W'(COLUMNS - 1));
    assign slot_free = !out_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            albar_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = albar_pkg::BK_DRAW;
                end
            end
            albar_pkg::BK_DRAW:
            begin
                if (slot_free && col_last)
                begin
                    state_next = albar_pkg::BK_IDLE;
                end
            end
            default: state_next = albar_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop = 1'b0;
        emit  = 1'b0;
        case (state_reg)
            albar_pkg::BK_IDLE: q_pop = q_valid;
            albar_pkg::BK_DRAW: emit  = slot_free;
            default:
            begin
                q_pop = 1'b0;
                emit  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= albar_pkg::BK_IDLE;
            col_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                col_reg  <= '0;
                used_reg <= '0;
            end
            else if (emit)
            begin
                col_reg  <= col_reg + 1'b1;
                used_reg <= used_reg + PIX_W'(PIXELS_PER_COLUMN);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pix_reg <= pix_sat;
        end
        if (emit)
        begin
            out_char_reg <= glyph;
            out_col_reg  <= albar_pkg::COLUMN_W'(col_reg);
            out_last_reg <= col_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = albar_pkg::OUT_DATA_W'({out_col_reg, out_char_reg});
    assign m_tlast  = out_last_reg;

endmodule

### rtl/core/averaged_level_lcd_bargraph_unit.sv
// ----------------------------------------------------------------------------
// averaged_level_lcd_bargraph_unit: averaged level bar graph
// Leaky average of converter samples, drawn as a row of bar characters.
//
// s_* channel: one converter sample per transfer (tdata bits [SAMPLE_BITS-1:0]).
// m_* channel: one character per transfer, COLUMNS transfers per redraw,
//   tlast on the rightmost column.
// cfg_* channel: refresh period (samples between redraws), always ready.
//
// Throughput: one sample per cycle. A redraw puts its average into a
// two-entry queue; the drawing side pops it, then emits one column per
// cycle while the output register is free. Samples are held off only
// while the queue is full. A sample's average passes the queue, the
// drawing side's pixel register and the output register in turn.
// Reset: sum and countdown clear, so the first sample redraws; the
// period returns to 625. A stalled receiver holds the output register
// and backs up into the queue, then into the sample input.
// ----------------------------------------------------------------------------
module averaged_level_lcd_bargraph_unit #(
    parameter int COLUMNS           = 16,
    parameter int PIXELS_PER_COLUMN = 5,
    parameter int AVERAGE_SHIFT     = 3,
    parameter int SAMPLE_BITS       = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,   // sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [albar_pkg::OUT_DATA_W-1:0] m_tdata,   // char_code, column
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [albar_pkg::PERIOD_W-1:0]   cfg_data
);

    localparam int IN_W = ((SAMPLE_BITS + 7) / 8) * 8;

    logic                   q_push;
    logic [SAMPLE_BITS-1:0] q_wdata;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_valid;
    logic [SAMPLE_BITS-1:0] q_rdata;

    albar_front #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .AVERAGE_SHIFT(AVERAGE_SHIFT),
        .IN_W         (IN_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .q_full   (q_full)
    );

    albar_queue #(
        .DATA_W(SAMPLE_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_wdata),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_data (q_rdata)
    );

    albar_back #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .COLUMNS          (COLUMNS),
        .PIXELS_PER_COLUMN(PIXELS_PER_COLUMN)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_full)
        else $error("sample input stalled with queue space free");

    a_last_column: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |->
            (m_tdata[11:8] == albar_pkg::COLUMN_W'(COLUMNS - 1)))
        else $error("tlast on wrong column");

    a_column_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tdata[11:8] == $past(m_tdata[11:8]) + 4'd1)))
        else $error("bar graph columns not contiguous");

endmodule

### verif/averaged_level_lcd_bargraph_unit_test.sv
// ----------------------------------------------------------------------------
// averaged_level_lcd_bargraph_unit_test: bar graph unit testbench
// Streams converter samples into the unit, tracks the leaky average and the
// redraw countdown alongside it, and checks every column transfer against the
// predicted character, column index and tlast. Runs a zero period, short
// periods and the largest period, with random gaps on the sample side and
// random stalls on the column side.
// ----------------------------------------------------------------------------
module averaged_level_lcd_bargraph_unit_test;

    localparam int COLUMNS           = 16;
    localparam int PIXELS_PER_COLUMN = 5;
    localparam int AVERAGE_SHIFT     = 3;
    localparam int SAMPLE_BITS       = 10;

    localparam int IN_W         = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SUM_W        = SAMPLE_BITS + AVERAGE_SHIFT;
    localparam int MAX_PIX      = COLUMNS * PIXELS_PER_COLUMN;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed
    {
        logic [albar_pkg::CHAR_W-1:0]   char_code;
        logic [albar_pkg::COLUMN_W-1:0] column;
        logic                           last;
    } bar_cell_t;

    // Tracks the averaged level and the redraw countdown; holds the columns
    // still owed by the unit.
    class bargraph_tracker;
        logic [SUM_W-1:0]               level_sum;
        logic [albar_pkg::PERIOD_W-1:0] countdown;
        logic [albar_pkg::PERIOD_W-1:0] period;
        bar_cell_t                      pending_cells[$];
        int                             mismatches;

        function new();
            level_sum   = '0;
            countdown   = '0;
            period      = albar_pkg::PERIOD_RESET;
            mismatches  = 0;
        endfunction

        function void set_period(logic [albar_pkg::PERIOD_W-1:0] value);
            period = value;
        endfunction

        function void take_sample(logic [IN_W-1:0] word);
            logic [SAMPLE_BITS-1:0] sample;
            logic [SAMPLE_BITS-1:0] avg;
            int                     pix;
            int                     used;
            bar_cell_t              col_item;
            sample    = word[SAMPLE_BITS-1:0];
            // average is taken before the sum moves
            avg       = SAMPLE_BITS'(level_sum >> AVERAGE_SHIFT);
            level_sum = level_sum + SUM_W'(sample) - SUM_W'(avg);
            if (countdown != 0)
                countdown = countdown - 1'b1;
            if (countdown != 0)
                return;
            countdown = period;
            pix = int'(avg) / albar_pkg::PIXEL_DIVISOR;
            if (pix > MAX_PIX)
                pix = MAX_PIX;
            for (int k = 0; k < COLUMNS; k++)
            begin
                used = k * PIXELS_PER_COLUMN;
                if (pix <= used)
                    col_item.char_code = albar_pkg::SPACE_CODE;
                else if (pix - used >= PIXELS_PER_COLUMN)
                    col_item.char_code = albar_pkg::CHAR_W'(PIXELS_PER_COLUMN - 1);
                else
                    col_item.char_code = albar_pkg::CHAR_W'(pix - used - 1);
                col_item.column = albar_pkg::COLUMN_W'(k);
                col_item.last   = (k == COLUMNS - 1);
                pending_cells.push_back(col_item);
            end
        endfunction

        function void check_cell(logic [albar_pkg::OUT_DATA_W-1:0] data, logic last);
            bar_cell_t want;
            if (pending_cells.size() == 0)
            begin
                $error("unexpected column transfer: tdata %h tlast %b", data, last);
                mismatches++;
                return;
            end
            want = pending_cells.pop_front();
            if (data[albar_pkg::CHAR_W-1:0] !== want.char_code)
            begin
                $error("char_code mismatch: expected %0d, actual %0d",
                       want.char_code, data[albar_pkg::CHAR_W-1:0]);
                mismatches++;
            end
            if (data[albar_pkg::CHAR_W +: albar_pkg::COLUMN_W] !== want.column)
            begin
                $error("column mismatch: expected %0d, actual %0d",
                       want.column, data[albar_pkg::CHAR_W +: albar_pkg::COLUMN_W]);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("last mismatch: expected %0b, actual %0b", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [IN_W-1:0]                  s_tdata   = '0;      // sample
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [albar_pkg::OUT_DATA_W-1:0] m_tdata;             // char_code, column
    logic                             m_tlast;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [albar_pkg::PERIOD_W-1:0]   cfg_data  = '0;

    bargraph_tracker board = new();
    bit              bursts_on = 1'b1;
    int              stall_left = 0;
    int              quiet_cycles = 0;

    averaged_level_lcd_bargraph_unit #(
        .COLUMNS           (COLUMNS),
        .PIXELS_PER_COLUMN (PIXELS_PER_COLUMN),
        .AVERAGE_SHIFT     (AVERAGE_SHIFT),
        .SAMPLE_BITS       (SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // column side: random stall bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end
        else
            m_tready <= 1'b1;
    end

    // transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.set_period(cfg_data);
            if (s_tvalid && s_tready)
                board.take_sample(s_tdata);
            if (m_tvalid && m_tready)
                board.check_cell(m_tdata, m_tlast);
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // called and returns at a falling edge
    task automatic push_sample(input logic [IN_W-1:0] word);
        if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic write_period(input logic [albar_pkg::PERIOD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait for every owed column, then let any sample still inside finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending_cells.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // level held for a while with small noise, so the average sweeps the range;
    // a few raw words with the padding bits set, and some rail values
    task automatic run_levels(input int count);
        int              level;
        int              s;
        logic [IN_W-1:0] word;
        level = $urandom_range(0, 1023);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                level = $urandom_range(0, 1023);
            case ($urandom_range(0, 9))
                0: word = IN_W'($urandom);
                1: word = $urandom_range(0, 1) ? IN_W'(1023) : '0;
                default:
                begin
                    s = level + $urandom_range(0, 32) - 16;
                    if (s < 0)
                        s = 0;
                    if (s > 1023)
                        s = 1023;
                    word = IN_W'(s);
                end
            endcase
            push_sample(word);
        end
    endtask

    initial
    begin
        logic [IN_W-1:0] directed [20];
        for (int i = 0; i < 12; i++)
            directed[i] = 16'h03FF;
        directed[12] = 16'h02AA;
        directed[13] = 16'h0155;
        directed[14] = 16'hFC00;   // padding bits only
        directed[15] = 16'hFFFF;
        directed[16] = 16'h0000;
        directed[17] = 16'h0000;
        directed[18] = 16'h0200;
        directed[19] = 16'h0001;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero period: every sample redraws, starting with the first one,
        // which sees a zero average
        write_period('0);
        push_sample(16'h03FF);
        run_levels(150);
        foreach (directed[i])
            push_sample(directed[i]);

        settle();
        write_period(albar_pkg::PERIOD_W'(1));
        run_levels(40);

        settle();
        write_period(albar_pkg::PERIOD_W'($urandom_range(2, 7)));
        run_levels(40);

        settle();
        write_period(albar_pkg::PERIOD_W'($urandom_range(8, 24)));
        run_levels(20);
        bursts_on = 1'b0;
        run_levels(20);

        settle();
        write_period('1);
        run_levels(30);

        settle();
        if (board.pending_cells.size() != 0)
        begin
            $error("%0d columns never arrived", board.pending_cells.size());
            board.mismatches++;
        end
        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
